/* rtl/core/binary_to_seven_segment_digits_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the binary to seven-segment digit converter
// Implication forms that are checked on every clock edge outside reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_SEVEN_SEGMENT_DIGITS_TOP_ASSERT_SVH
`define BINARY_TO_SEVEN_SEGMENT_DIGITS_TOP_ASSERT_SVH

// same-cycle implication
`define BSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bss: implication check failed");

// next-cycle implication
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bss: next-cycle check failed");

`endif

/* rtl/core/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, constants and functions of the seven-segment digit converter.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int unsigned VALUE_W         = 16;
    localparam int unsigned SEG_W           = 8;
    localparam int unsigned NUM_DIGITS      = 4;
    localparam int unsigned DIGIT_W         = 4;
    localparam int unsigned BCD_W           = NUM_DIGITS * DIGIT_W;
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned DABBLE_STAGES   = VALUE_W / STEPS_PER_STAGE;
    localparam int unsigned LATENCY         = DABBLE_STAGES + 1;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2,
        BASE_BIN = 2'd3
    } t_base;

    typedef struct packed {
        t_base              base;
        logic [VALUE_W-1:0] value;
        logic [BCD_W-1:0]   bcd;
    } t_dab;

    // active-low segment code of one digit
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'h0: code = 8'b11000000;
            4'h1: code = 8'b11111001;
            4'h2: code = 8'b10100100;
            4'h3: code = 8'b10110000;
            4'h4: code = 8'b10011001;
            4'h5: code = 8'b10010010;
            4'h6: code = 8'b10000010;
            4'h7: code = 8'b11111000;
            4'h8: code = 8'b10000000;
            4'h9: code = 8'b10011000;
            4'hA: code = 8'h88;
            4'hB: code = 8'h83;
            4'hC: code = 8'hC6;
            4'hD: code = 8'hA1;
            4'hE: code = 8'h86;
            default: code = 8'h8E;
        endcase
        return code;
    endfunction

    // one shift-and-add-3 step; digits carried out of the top are dropped,
    // which leaves the value mod 10000
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                      input logic             bit_in);
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] nib;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            nib = bcd[k*DIGIT_W +: DIGIT_W];
            if (nib >= 4'd5) begin
                nib = nib + 4'd3;
            end
            adj[k*DIGIT_W +: DIGIT_W] = nib;
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

/* rtl/core/binary_to_seven_segment_digits_top.sv */
// ----------------------------------------------------------------------------
// binary_to_seven_segment_digits_top
// 16-bit value to four active-low seven-segment digits plus a colon slot.
// ----------------------------------------------------------------------------
// A value is taken on every clock in which start is high and busy is low;
// busy is high during reset and in the cycle right after it. Each value
// gives one result word, shown on the segment outputs for one cycle with
// o_valid high after four stages of decimal conversion (four shift-and-add-3
// steps each), then one stage of digit select, leading zero blanking and
// segment decode. One value per cycle is sustained while busy is low. The
// receiver cannot stall the pipeline. digit_base (0 dec, 1 hex, 2 oct, 3 bin)
// is the APB register (paddr not decoded), sampled when a value is accepted.
// ----------------------------------------------------------------------------
module binary_to_seven_segment_digits_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_value,
    // result channel
    output logic        o_valid,
    output logic [7:0]  o_ones_segments,
    output logic [7:0]  o_second_segments,
    output logic [7:0]  o_colon_segments,
    output logic [7:0]  o_third_segments,
    output logic [7:0]  o_top_segments,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned DS  = bss_pkg::DABBLE_STAGES;
    localparam int unsigned SPS = bss_pkg::STEPS_PER_STAGE;
    localparam int unsigned DW  = bss_pkg::DIGIT_W;
    localparam int unsigned ND  = bss_pkg::NUM_DIGITS;

    bss_pkg::t_base r_digit_base;
    logic           r_busy;
    logic           w_accept;

    bss_pkg::t_dab  r_dab [DS];
    bss_pkg::t_dab  n_dab [DS];
    logic           r_vld [DS];
    logic           n_vld [DS];

    logic [bss_pkg::SEG_W-1:0] r_seg [ND];
    logic [bss_pkg::SEG_W-1:0] n_seg [ND];
    logic                      r_out_vld;

    logic [DW-1:0] w_digit [ND];
    logic          w_blank [ND];

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = {30'd0, r_digit_base};

    // one register: the byte offset is not decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_base <= bss_pkg::BASE_DEC;
        end else if (psel && penable && pwrite && pready) begin
            r_digit_base <= bss_pkg::t_base'(pwdata[1:0]);
        end
    end

    // hold busy through the cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // ---------------- conversion stages ----------------
    for (genvar s = 0; s < DS; s++) begin : g_stage
        bss_pkg::t_dab w_src;
        logic          w_src_vld;

        if (s == 0) begin : g_first
            always_comb begin
                w_src.base  = r_digit_base;
                w_src.value = i_value;
                w_src.bcd   = '0;
                w_src_vld   = w_accept;
            end
        end else begin : g_rest
            always_comb begin
                w_src     = r_dab[s-1];
                w_src_vld = r_vld[s-1];
            end
        end

        // advance four bits, msb first
        always_comb begin
            n_dab[s] = w_src;
            n_vld[s] = w_src_vld;
            for (int j = 0; j < SPS; j++) begin
                n_dab[s].bcd = bss_pkg::dabble_step(n_dab[s].bcd,
                                                    w_src.value[bss_pkg::VALUE_W-1-s*SPS-j]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= n_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dab[s] <= n_dab[s];
        end
    end

    // ---------------- digit select, blanking, decode ----------------
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            case (r_dab[DS-1].base)
                bss_pkg::BASE_DEC: w_digit[k] = r_dab[DS-1].bcd[k*DW +: DW];
                bss_pkg::BASE_HEX: w_digit[k] = r_dab[DS-1].value[k*4 +: 4];
                bss_pkg::BASE_OCT: w_digit[k] = {1'b0, r_dab[DS-1].value[k*3 +: 3]};
                default:           w_digit[k] = {3'd0, r_dab[DS-1].value[k]};
            endcase
        end
    end

    // blank zeros from the top down; the lowest digit always shows
    always_comb begin
        w_blank[ND-1] = (w_digit[ND-1] == '0);
        for (int k = ND - 2; k >= 1; k--) begin
            w_blank[k] = w_blank[k+1] && (w_digit[k] == '0);
        end
        w_blank[0] = 1'b0;
    end

    always_comb begin
        for (int k = 0; k < ND; k++) begin
            n_seg[k] = w_blank[k] ? bss_pkg::SEG_BLANK : bss_pkg::seg_code(w_digit[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[DS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ND; k++) begin
            r_seg[k] <= n_seg[k];
        end
    end

    assign o_valid           = r_out_vld;
    assign o_ones_segments   = r_seg[0];
    assign o_second_segments = r_seg[1];
    assign o_colon_segments  = bss_pkg::SEG_BLANK;
    assign o_third_segments  = r_seg[2];
    assign o_top_segments    = r_seg[3];

endmodule

/* rtl/core/bss_checker.sv */
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks of latency and display rules of the digit converter.
// ----------------------------------------------------------------------------
`include "binary_to_seven_segment_digits_top_assert.svh"

module bss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_ones_segments,
    input logic [7:0] o_colon_segments,
    input logic [7:0] o_top_segments
);

    logic w_accept;
    logic w_digits_ok;

    assign w_accept    = start && !busy;
    // top digit never shows a zero, lowest digit never goes blank
    assign w_digits_ok = (o_top_segments != bss_pkg::seg_code(4'h0))
                      && (o_ones_segments != bss_pkg::SEG_BLANK);

    `BSS_ASSERT_IMPLY(a_word_latency, i_clk, i_rst_n, $past(w_accept, bss_pkg::LATENCY), o_valid)
    `BSS_ASSERT_IMPLY(a_no_spurious_word, i_clk, i_rst_n, o_valid, $past(w_accept, bss_pkg::LATENCY))
    `BSS_ASSERT_IMPLY(a_top_zero_blanked, i_clk, i_rst_n, o_valid, w_digits_ok)
    `BSS_ASSERT_IMPLY(a_colon_off, i_clk, i_rst_n, o_valid, o_colon_segments == bss_pkg::SEG_BLANK)
    `BSS_ASSERT_NEXT(a_busy_after_reset, i_clk, i_rst_n, i_rst_n, !busy)

endmodule

bind binary_to_seven_segment_digits_top bss_checker u_bss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_ones_segments  (o_ones_segments),
    .o_colon_segments (o_colon_segments),
    .o_top_segments   (o_top_segments)
);

/* verif/binary_to_seven_segment_digits_top_tb.sv */
// ----------------------------------------------------------------------------
// binary_to_seven_segment_digits_top_tb
// Self-checking bench for the value to seven-segment digit converter: values
// are fed through the start/busy command port in phases, one digit base per
// phase, and each result word is compared with a predicted display pattern.
// ----------------------------------------------------------------------------
module binary_to_seven_segment_digits_top_tb;

    localparam logic [1:0] DIGIT_BASE_ADDR = 2'd0;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned IDLE_PERCENT   = 7;
    // active-low glyphs 0..F, digit d at bits [8*d +: 8]
    localparam logic [16*8-1:0] GLYPHS = {
        8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h98, 8'h80,
        8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    typedef struct {
        logic [bss_pkg::VALUE_W-1:0] value;
        bit                          drain;
    } t_value_req;

    typedef struct {
        logic [bss_pkg::SEG_W-1:0] ones;
        logic [bss_pkg::SEG_W-1:0] second;
        logic [bss_pkg::SEG_W-1:0] colon;
        logic [bss_pkg::SEG_W-1:0] third;
        logic [bss_pkg::SEG_W-1:0] top;
    } t_display;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_value;
    logic        o_valid;
    logic [7:0]  o_ones_segments;
    logic [7:0]  o_second_segments;
    logic [7:0]  o_colon_segments;
    logic [7:0]  o_third_segments;
    logic [7:0]  o_top_segments;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_value_req     pending_values[$];
    t_display       expected_displays[$];
    bss_pkg::t_base base_cfg;
    int             in_flight;
    int             mismatches    = 0;
    int             words_checked = 0;
    int             base_items[4] = '{default: 0};
    int unsigned    cycles        = 0;
    bit             steady;

    binary_to_seven_segment_digits_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_value           (i_value),
        .o_valid           (o_valid),
        .o_ones_segments   (o_ones_segments),
        .o_second_segments (o_second_segments),
        .o_colon_segments  (o_colon_segments),
        .o_third_segments  (o_third_segments),
        .o_top_segments    (o_top_segments),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // expected display for one value in the given base
    function automatic t_display display_of(input logic [bss_pkg::VALUE_W-1:0] v,
                                            input bss_pkg::t_base b);
        logic [3:0]                dig [4];
        logic [bss_pkg::SEG_W-1:0] seg [4];
        int unsigned               w;
        bit                        lead;
        t_display                  d;
        if (b == bss_pkg::BASE_DEC) begin
            dig[0] = 4'(v % 10);
            dig[1] = 4'((v / 10) % 10);
            dig[2] = 4'((v / 100) % 10);
            dig[3] = 4'((v / 1000) % 10);
        end else begin
            w = (b == bss_pkg::BASE_HEX) ? 4 : (b == bss_pkg::BASE_OCT) ? 3 : 1;
            for (int k = 0; k < 4; k++) begin
                dig[k] = 4'((32'(v) >> (w * k)) & ((32'd1 << w) - 1));
            end
        end
        // blank leading zeros; the lowest digit always shows
        lead = 1'b1;
        for (int k = 3; k >= 0; k--) begin
            if (lead && k > 0 && dig[k] == 4'd0) begin
                seg[k] = bss_pkg::SEG_BLANK;
            end else begin
                lead   = 1'b0;
                seg[k] = GLYPHS[dig[k]*8 +: 8];
            end
        end
        d.ones   = seg[0];
        d.second = seg[1];
        d.colon  = bss_pkg::SEG_BLANK;
        d.third  = seg[2];
        d.top    = seg[3];
        return d;
    endfunction

    function automatic logic [bss_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 15));
            2: return 16'(16'($urandom_range(0, 255)) << $urandom_range(0, 12));
            3: return 16'(10000 * $urandom_range(1, 6) + $urandom_range(0, 99));
            default: return 16'(65535 - $urandom_range(0, 15));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [bss_pkg::SEG_W-1:0] exp_v,
                               input logic [bss_pkg::SEG_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %02h, got %02h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic queue_value(input logic [bss_pkg::VALUE_W-1:0] v, input bit drain);
        t_value_req req;
        req.value = v;
        req.drain = drain;
        pending_values.push_back(req);
    endtask

    // wait until every queued word is taken and every result is back
    task automatic drain_pipeline();
        do @(negedge i_clk);
        while (pending_values.size() != 0 || start || in_flight != 0);
        repeat (bss_pkg::LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_digit_base(input bss_pkg::t_base b);
        logic [31:0] word;
        word      = $urandom();
        word[1:0] = b;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIGIT_BASE_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // command driver: one word per handshake, random gaps, optional drain hold
    always @(posedge i_clk) begin : value_driver
        bit taken;
        int settled;
        taken = start && !busy;
        if (!i_rst_n) begin
            start   <= 1'b0;
            i_value <= '0;
        end else if (start && !taken) begin
            // hold the word until accepted
        end else begin
            if (taken) begin
                pending_values.delete(0);
            end
            settled = in_flight + int'(taken) - int'(o_valid);
            if (pending_values.size() != 0
                    && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)
                    && (!pending_values[0].drain || settled == 0)) begin
                start   <= 1'b1;
                i_value <= pending_values[0].value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: track the base register, predict on accept, compare on strobe
    always @(posedge i_clk) begin : result_monitor
        t_display want;
        if (!i_rst_n) begin
            base_cfg  = bss_pkg::BASE_DEC;
            in_flight <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == DIGIT_BASE_ADDR) begin
                base_cfg = bss_pkg::t_base'(pwdata[1:0]);
            end
            if (start && !busy) begin
                expected_displays.push_back(display_of(i_value, base_cfg));
                base_items[base_cfg]++;
            end
            if (o_valid) begin
                if (expected_displays.size() == 0) begin
                    $error("result word with no value outstanding");
                    mismatches++;
                end else begin
                    want = expected_displays.pop_front();
                    check_field("ones_segments", want.ones, o_ones_segments);
                    check_field("second_segments", want.second, o_second_segments);
                    check_field("colon_segments", want.colon, o_colon_segments);
                    check_field("third_segments", want.third, o_third_segments);
                    check_field("top_segments", want.top, o_top_segments);
                    words_checked++;
                end
            end
            in_flight <= in_flight + int'(start && !busy) - int'(o_valid);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        bss_pkg::t_base phase_bases [8];
        phase_bases = '{bss_pkg::BASE_BIN, bss_pkg::BASE_HEX, bss_pkg::BASE_DEC,
                        bss_pkg::BASE_OCT, bss_pkg::BASE_DEC, bss_pkg::BASE_BIN,
                        bss_pkg::BASE_HEX, bss_pkg::BASE_OCT};
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        steady  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // decimal from reset: zero, wrap past 9999 to all-zero, inner zeros
        @(negedge i_clk);
        queue_value(16'd0, 1'b0);
        queue_value(16'd7, 1'b0);
        queue_value(16'd10000, 1'b0);
        queue_value(16'd9999, 1'b0);
        queue_value(16'd65535, 1'b0);
        queue_value(16'd1005, 1'b0);
        drain_pipeline();

        // hex: every letter, zero nibbles below a set one, full scale
        write_digit_base(bss_pkg::BASE_HEX);
        @(negedge i_clk);
        queue_value(16'hABCD, 1'b0);
        queue_value(16'h00EF, 1'b0);
        queue_value(16'h0100, 1'b0);
        queue_value(16'hFFFF, 1'b0);
        queue_value(16'h0000, 1'b0);
        drain_pipeline();

        // octal: bits above the four fields vanish
        write_digit_base(bss_pkg::BASE_OCT);
        @(negedge i_clk);
        queue_value(16'h7000, 1'b0);
        queue_value(16'h0FFF, 1'b0);
        queue_value(16'h0008, 1'b0);
        queue_value(16'h8E00, 1'b0);
        queue_value(16'h0005, 1'b0);
        drain_pipeline();

        // binary: only the low four bits show
        write_digit_base(bss_pkg::BASE_BIN);
        @(negedge i_clk);
        queue_value(16'hFFF0, 1'b0);
        queue_value(16'h000F, 1'b0);
        queue_value(16'h0008, 1'b0);
        queue_value(16'h0001, 1'b0);
        queue_value(16'h0005, 1'b0);
        queue_value(16'h5A5A, 1'b0);
        drain_pipeline();

        for (int p = 0; p < 8; p++) begin
            write_digit_base(phase_bases[p]);
            steady = (p == 2);
            @(negedge i_clk);
            for (int n = 0; n < 97; n++) begin
                queue_value(pick_value(), (p == 1 && n == 50) || $urandom_range(0, 99) == 0);
            end
            drain_pipeline();
        end

        if (expected_displays.size() != 0) begin
            $error("%0d result words never arrived", expected_displays.size());
        end
        $display("Converted %0d values: dec %0d, hex %0d, oct %0d, bin %0d",
                 base_items[0] + base_items[1] + base_items[2] + base_items[3],
                 base_items[bss_pkg::BASE_DEC], base_items[bss_pkg::BASE_HEX],
                 base_items[bss_pkg::BASE_OCT], base_items[bss_pkg::BASE_BIN]);
        $display("Checked %0d result words over %0d cycles", words_checked, cycles);
        if (mismatches == 0 && expected_displays.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bss_pkg.sv
rtl/core/binary_to_seven_segment_digits_top.sv
rtl/core/bss_checker.sv
verif/binary_to_seven_segment_digits_top_tb.sv
